### rtl/core/zwf_pkg.sv
// Shared types, frame constants and the CRC-16 byte update for the zone write framer.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package zwf_pkg;

  localparam logic [7:0]  FrameHeader  = 8'h7E;
  localparam logic [7:0]  FramePad     = 8'h00;
  localparam logic [7:0]  FrameLenByte = 8'h01;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] CrcInit      = 16'h0000;

  // Five bytes are covered by the CRC: type, length, address high, address low, value
  localparam int unsigned CrcSpanLen = 5;
  localparam int unsigned StepW      = $clog2(CrcSpanLen + 1);
  typedef logic [StepW-1:0] step_t;

  localparam logic [StepW-1:0] SpanType     = StepW'(0);
  localparam logic [StepW-1:0] SpanLen      = StepW'(1);
  localparam logic [StepW-1:0] SpanAddrHigh = StepW'(2);
  localparam logic [StepW-1:0] SpanAddrLow  = StepW'(3);
  localparam logic [StepW-1:0] SpanDone     = StepW'(CrcSpanLen);

  // Byte positions in the transmitted frame
  localparam int unsigned FrameBytes = 9;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  typedef logic [IdxW-1:0] idx_t;

  localparam logic [IdxW-1:0] PosHeader   = IdxW'(0);
  localparam logic [IdxW-1:0] PosPad      = IdxW'(1);
  localparam logic [IdxW-1:0] PosType     = IdxW'(2);
  localparam logic [IdxW-1:0] PosLen      = IdxW'(3);
  localparam logic [IdxW-1:0] PosAddrHigh = IdxW'(4);
  localparam logic [IdxW-1:0] PosAddrLow  = IdxW'(5);
  localparam logic [IdxW-1:0] PosValue    = IdxW'(6);
  localparam logic [IdxW-1:0] PosCrcHigh  = IdxW'(7);
  localparam logic [IdxW-1:0] PosCrcLow   = IdxW'(8);

  // One framed command, CRC already worked out
  typedef struct packed {
    logic [7:0]  frame_type;
    logic [15:0] zone_address;
    logic [7:0]  zone_value;
    logic [15:0] crc;
  } frame_rec_t;

  // Queue status seen by the front end and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // CRC-16, MSB first: fold one byte into the running remainder
  function automatic logic [15:0] crc_feed_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/zwf_front.sv
// Front end: accepts a write command and runs the CRC over its five covered bytes.
// Depends on zwf_pkg; hands finished records to zwf_queue.
`timescale 1ns / 1ps

module zwf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  logic [7:0]         frame_type_i,
  input  logic [15:0]        zone_address_i,
  input  logic [7:0]         zone_value_i,
  input  zwf_pkg::q_stat_t   q_stat_i,
  output logic               push_o,
  output zwf_pkg::frame_rec_t rec_o
);
  import zwf_pkg::*;

  logic        busy_q, busy_d;
  step_t       step_q, step_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  value_q, value_d;
  logic [7:0]  span_byte;
  logic        done;
  logic        accept;

  always_comb begin
    case (step_q)
      SpanType:     span_byte = type_q;
      SpanLen:      span_byte = FrameLenByte;
      SpanAddrHigh: span_byte = addr_q[15:8];
      SpanAddrLow:  span_byte = addr_q[7:0];
      default:      span_byte = value_q;
    endcase
  end

  assign done        = busy_q && (step_q == SpanDone);
  assign push_o      = done && !q_stat_i.full;
  assign cmd_ready_o = !busy_q || push_o;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    crc_d   = crc_q;
    type_d  = type_q;
    addr_d  = addr_q;
    value_d = value_q;
    if (accept) begin
      busy_d  = 1'b1;
      step_d  = '0;
      crc_d   = CrcInit;
      type_d  = frame_type_i;
      addr_d  = zone_address_i;
      value_d = zone_value_i;
    end else if (push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && !done) begin
      crc_d  = crc_feed_byte(crc_q, span_byte);
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    type_q  <= type_d;
    addr_q  <= addr_d;
    value_q <= value_d;
  end

  assign rec_o = '{frame_type: type_q, zone_address: addr_q,
                   zone_value: value_q, crc: crc_q};

endmodule

### rtl/core/zwf_queue.sv
// Short record queue between the CRC front end and the byte serialiser.
// Depends on zwf_pkg for the record type and depth.
`timescale 1ns / 1ps

module zwf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  zwf_pkg::frame_rec_t push_rec_i,
  input  logic                pop_i,
  output zwf_pkg::frame_rec_t head_rec_o,
  output zwf_pkg::q_stat_t    stat_o
);
  import zwf_pkg::*;

  frame_rec_t             slot_q [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       count_q, count_d;
  logic                   do_push, do_pop;

  assign stat_o.full  = (count_q == QCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_rec_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + QCntW'(1);
      2'b01:   count_d = count_q - QCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

### rtl/core/zwf_back.sv
// Back end: serialises one queued record into the nine frame bytes through an output register.
// Depends on zwf_pkg; pulls records from zwf_queue.
`timescale 1ns / 1ps

module zwf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zwf_pkg::q_stat_t    q_stat_i,
  input  zwf_pkg::frame_rec_t head_rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);
  import zwf_pkg::*;

  frame_rec_t  cur_q, cur_d;
  logic        cur_v_q, cur_v_d;
  idx_t        idx_q, idx_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d;
  logic        load, emit, fin;
  logic [7:0]  sel_byte;

  always_comb begin
    case (idx_q)
      PosHeader:   sel_byte = FrameHeader;
      PosPad:      sel_byte = FramePad;
      PosType:     sel_byte = cur_q.frame_type;
      PosLen:      sel_byte = FrameLenByte;
      PosAddrHigh: sel_byte = cur_q.zone_address[15:8];
      PosAddrLow:  sel_byte = cur_q.zone_address[7:0];
      PosValue:    sel_byte = cur_q.zone_value;
      PosCrcHigh:  sel_byte = cur_q.crc[15:8];
      default:     sel_byte = cur_q.crc[7:0];
    endcase
  end

  assign load  = !ov_q || out_ready_i;
  assign emit  = load && cur_v_q;
  assign fin   = emit && (idx_q == PosCrcLow);
  assign pop_o = !q_stat_i.empty && (!cur_v_q || fin);

  always_comb begin
    cur_d   = cur_q;
    cur_v_d = cur_v_q;
    idx_d   = idx_q;
    if (pop_o) begin
      cur_d   = head_rec_i;
      cur_v_d = 1'b1;
      idx_d   = '0;
    end else if (fin) begin
      cur_v_d = 1'b0;
    end else if (emit) begin
      idx_d = idx_q + IdxW'(1);
    end

    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    if (emit) begin
      ov_d = 1'b1;
      ob_d = sel_byte;
      ol_d = (idx_q == PosCrcLow);
    end else if (load) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_byte_o = ol_q;

endmodule

### rtl/core/zone_write_frame_crc16_top.sv
// Top level of the zone write framer: front end, record queue and byte serialiser.
// Depends on zwf_pkg, zwf_front, zwf_queue and zwf_back.
`timescale 1ns / 1ps
//
// Usage
//   The slave stream takes one register-write command per transaction; the
//   master stream gives the nine-byte frame for it, one byte per transaction:
//   0x7E, 0x00, type, 0x01, address high, address low, value, CRC high,
//   CRC low. m_axis_tlast marks the CRC low byte. The CRC is CRC-16 with
//   polynomial 0x1021, zero start, MSB first, over type..value.
// Flow
//   The front end folds one covered byte per cycle, and the next command can
//   be taken as the finished record leaves. Once a command is taken, its
//   record goes into the queue, then into the serialiser, and its first byte
//   is presented from the output register. While m_axis_tready is high the
//   serialiser sends one byte per cycle, so with the receiver always ready
//   the sustained rate is set by the nine output bytes.
// Reset
//   rst_ni clears the front end, the two-record queue and the output
//   register; no transaction is in flight afterwards.
// Stall
//   While m_axis_tready is low the output byte holds. The queue keeps up to
//   two finished records, then the front end holds its record and drops
//   s_axis_tready until space frees up.

module zone_write_frame_crc16_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] frame_type, [23:8] zone_address, [31:24] zone_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // last_byte
);
  import zwf_pkg::*;

  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  frame_rec_t push_rec;
  frame_rec_t head_rec;

  // Accept and CRC
  zwf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_o    (s_axis_tready),
    .frame_type_i   (s_axis_tdata[7:0]),
    .zone_address_i (s_axis_tdata[23:8]),
    .zone_value_i   (s_axis_tdata[31:24]),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .rec_o          (push_rec)
  );

  // Decouple the two halves
  zwf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_rec_o (head_rec),
    .stat_o     (q_stat)
  );

  // Serialise bytes
  zwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_rec_i  (head_rec),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .last_byte_o (m_axis_tlast)
  );

endmodule

### rtl/core/zwf_checker.sv
// Port-level checker for the zone write framer, bound to the top level.
// Depends on zwf_pkg for frame constants and byte positions.
`timescale 1ns / 1ps

module zwf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);
  import zwf_pkg::*;

  idx_t pos_q;
  logic out_hs;

  assign out_hs = m_axis_tvalid && m_axis_tready;

  // Track the byte position within the current frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_hs) begin
      pos_q <= m_axis_tlast ? '0 : pos_q + IdxW'(1);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed under stall");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (pos_q == PosCrcLow)))
    else $error("tlast not on ninth byte");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (pos_q == PosHeader) |-> (m_axis_tdata == FrameHeader))
    else $error("frame does not open with header");

  a_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (pos_q == PosPad || pos_q == PosLen) |->
      (m_axis_tdata == ((pos_q == PosPad) ? FramePad : FrameLenByte)))
    else $error("pad or length byte wrong");

endmodule

bind zone_write_frame_crc16_top zwf_checker u_zwf_checker (.*);
